>>> rtl/ber_pkg.sv
// ----------------------------------------------------------------------------
// Bit error rate counter package
// Shared constants, the queue entry type and the byte popcount function.
// ----------------------------------------------------------------------------
`default_nettype none

package ber_pkg;

    // Default widths of the run counters and of the ratio fraction.
    localparam int COUNT_WIDTH_DEF   = 48;
    localparam int FRACTION_BITS_DEF = 32;

    // Fixed sizes of one byte pair.
    localparam int BYTE_W        = 8;
    localparam int POP_W         = 4;
    localparam int BITS_PER_PAIR = 8;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // One classified item as it travels through the queue.
    typedef struct packed {
        logic [POP_W-1:0] pop;
        logic             last;
    } t_pair_info;

    // Number of set bits in one byte.
    function automatic logic [POP_W-1:0] popcount8(input logic [BYTE_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ber_front.sv
// ----------------------------------------------------------------------------
// Bit error rate counter front part
// Accepts byte pairs, counts their differing bits and queues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ber_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_ref_byte,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic                  i_end_of_run,
    output logic                       o_q_valid,
    output ber_pkg::t_pair_info        o_q_data,
    input  wire logic                  i_q_ready
);
    import ber_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_pair_info             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_count;
    logic                   push;
    logic                   pop;
    t_pair_info             entry;

    // Classify the incoming item: differing bits and end of run.
    always_comb begin
        entry.pop  = popcount8(i_ref_byte ^ i_rx_byte);
        entry.last = i_end_of_run;
    end

    assign o_in_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_data   = r_mem[r_rd_ptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_q_valid && i_q_ready;

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= entry;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count above depth");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

>>> rtl/ber_div.sv
// ----------------------------------------------------------------------------
// Bit error rate counter divider
// Restoring divider giving one fraction bit per cycle of num / den.
// ----------------------------------------------------------------------------
`default_nettype none

module ber_div #(
    parameter int COUNT_WIDTH   = ber_pkg::COUNT_WIDTH_DEF,
    parameter int FRACTION_BITS = ber_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [COUNT_WIDTH-1:0]   i_num,
    input  wire logic [COUNT_WIDTH-1:0]   i_den,
    output logic                          o_busy,
    output logic [FRACTION_BITS:0]        o_quo
);
    localparam int CNT_W = $clog2(FRACTION_BITS + 1);

    logic [COUNT_WIDTH-1:0]   r_rem;
    logic [COUNT_WIDTH-1:0]   r_den;
    logic [FRACTION_BITS-1:0] r_quo;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_sat;
    logic                     r_zero;
    logic [COUNT_WIDTH:0]     shifted;
    logic                     take;

    // One trial subtraction of the doubled remainder.
    assign shifted = {r_rem, 1'b0};
    assign take    = (shifted >= {1'b0, r_den});
    assign o_busy  = (r_cnt != '0);

    // A ratio of one or more is exactly one; a zero total gives zero.
    always_comb begin
        if (r_sat) begin
            o_quo = {1'b1, {FRACTION_BITS{1'b0}}};
        end else if (r_zero) begin
            o_quo = '0;
        end else begin
            o_quo = {1'b0, r_quo};
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quo  <= '0;
            r_sat  <= (i_den != '0) && (i_num >= i_den);
            r_zero <= (i_den == '0);
        end else if (o_busy) begin
            r_quo <= {r_quo[FRACTION_BITS-2:0], take};
            if (take) begin
                r_rem <= COUNT_WIDTH'(shifted - {1'b0, r_den});
            end else begin
                r_rem <= shifted[COUNT_WIDTH-1:0];
            end
        end
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(FRACTION_BITS);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !o_busy)
        else $error("divider started while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_busy)
        else $error("divider did not start");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_busy && !r_sat && !r_zero) |-> (r_rem < r_den))
        else $error("remainder not below divisor");
`endif

endmodule

`default_nettype wire

>>> rtl/ber_back.sv
// ----------------------------------------------------------------------------
// Bit error rate counter back part
// Accumulates queued items, runs the ratio division and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ber_back #(
    parameter int COUNT_WIDTH   = ber_pkg::COUNT_WIDTH_DEF,
    parameter int FRACTION_BITS = ber_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_valid,
    input  wire ber_pkg::t_pair_info      i_q_data,
    output logic                          o_q_ready,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [COUNT_WIDTH-1:0]        o_error_bits,
    output logic [COUNT_WIDTH-1:0]        o_total_bits,
    output logic [FRACTION_BITS:0]        o_error_ratio
);
    import ber_pkg::*;

    typedef enum logic {
        S_ACC,
        S_DIV
    } t_state;

    t_state                   r_state, n_state;
    logic [COUNT_WIDTH-1:0]   r_err_acc, n_err_acc;
    logic [COUNT_WIDTH-1:0]   r_bit_acc, n_bit_acc;
    logic [COUNT_WIDTH-1:0]   r_res_err, n_res_err;
    logic [COUNT_WIDTH-1:0]   r_res_tot, n_res_tot;
    logic                     r_out_valid, n_out_valid;
    logic [COUNT_WIDTH-1:0]   r_out_err, n_out_err;
    logic [COUNT_WIDTH-1:0]   r_out_tot, n_out_tot;
    logic [FRACTION_BITS:0]   r_out_ratio, n_out_ratio;
    logic [COUNT_WIDTH:0]     err_sum;
    logic [COUNT_WIDTH:0]     bit_sum;
    logic [COUNT_WIDTH-1:0]   err_next;
    logic [COUNT_WIDTH-1:0]   bit_next;
    logic                     take;
    logic                     div_start;
    logic                     div_busy;
    logic [FRACTION_BITS:0]   div_quo;

    // Saturating counter updates: a carry out means the sum passed the maximum.
    assign err_sum  = {1'b0, r_err_acc} + (COUNT_WIDTH + 1)'(i_q_data.pop);
    assign bit_sum  = {1'b0, r_bit_acc} + (COUNT_WIDTH + 1)'(BITS_PER_PAIR);
    assign err_next = err_sum[COUNT_WIDTH] ? '1 : err_sum[COUNT_WIDTH-1:0];
    assign bit_next = bit_sum[COUNT_WIDTH] ? '1 : bit_sum[COUNT_WIDTH-1:0];

    assign o_q_ready = (r_state == S_ACC);
    assign take      = i_q_valid && o_q_ready;
    assign div_start = take && i_q_data.last;

    ber_div #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (err_next),
        .i_den   (bit_next),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // Next-state logic for accumulation, division wait and output register.
    always_comb begin
        n_state     = r_state;
        n_err_acc   = r_err_acc;
        n_bit_acc   = r_bit_acc;
        n_res_err   = r_res_err;
        n_res_tot   = r_res_tot;
        n_out_valid = r_out_valid;
        n_out_err   = r_out_err;
        n_out_tot   = r_out_tot;
        n_out_ratio = r_out_ratio;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_ACC: begin
                if (take) begin
                    if (i_q_data.last) begin
                        n_res_err = err_next;
                        n_res_tot = bit_next;
                        n_err_acc = '0;
                        n_bit_acc = '0;
                        n_state   = S_DIV;
                    end else begin
                        n_err_acc = err_next;
                        n_bit_acc = bit_next;
                    end
                end
            end
            S_DIV: begin
                if (!div_busy && (!r_out_valid || i_out_ready)) begin
                    n_out_valid = 1'b1;
                    n_out_err   = r_res_err;
                    n_out_tot   = r_res_tot;
                    n_out_ratio = div_quo;
                    n_state     = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_err_acc   <= '0;
            r_bit_acc   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_err_acc   <= n_err_acc;
            r_bit_acc   <= n_bit_acc;
            r_out_valid <= n_out_valid;
        end
        r_res_err   <= n_res_err;
        r_res_tot   <= n_res_tot;
        r_out_err   <= n_out_err;
        r_out_tot   <= n_out_tot;
        r_out_ratio <= n_out_ratio;
    end

    assign o_out_valid   = r_out_valid;
    assign o_error_bits  = r_out_err;
    assign o_total_bits  = r_out_tot;
    assign o_error_ratio = r_out_ratio;

`ifndef SYNTH
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_err_acc == '0) && (r_bit_acc == '0))
        else $error("counters not cleared after end of run");
    a_err_le_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err_acc <= r_bit_acc))
        else $error("error count above total count");
    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !div_busy && (!r_out_valid || i_out_ready))
        |=> (r_out_valid && r_state == S_ACC))
        else $error("finished result not loaded");
`endif

endmodule

`default_nettype wire

>>> rtl/bit_error_rate_counter.sv
// Accepted items are queued; an end-of-run item taken from the queue starts the
// divider; the result is loaded once the divider is idle and the output register free.
// Throughput: one byte pair per cycle within a run; the end-of-run pair holds the back
// part while the one-bit-per-cycle divider runs, longer while the previous result waits,
// so the input stalls once QUEUE_DEPTH items are queued.
// Reset: synchronous, active low; clears the queue, both counters and the output valid.
// ----------------------------------------------------------------------------
// Bit error rate counter
// Counts differing bits between two byte streams and reports the run ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_error_rate_counter #(
    parameter int COUNT_WIDTH   = ber_pkg::COUNT_WIDTH_DEF,
    parameter int FRACTION_BITS = ber_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [7:0]               i_ref_byte,
    input  wire logic [7:0]               i_rx_byte,
    input  wire logic                     i_end_of_run,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [COUNT_WIDTH-1:0]        o_error_bits,
    output logic [COUNT_WIDTH-1:0]        o_total_bits,
    output logic [FRACTION_BITS:0]        o_error_ratio
);
    import ber_pkg::*;

    logic       q_valid;
    logic       q_ready;
    t_pair_info q_data;

    // Front part: classify items and queue them.
    ber_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ref_byte   (i_ref_byte),
        .i_rx_byte    (i_rx_byte),
        .i_end_of_run (i_end_of_run),
        .o_q_valid    (q_valid),
        .o_q_data     (q_data),
        .i_q_ready    (q_ready)
    );

    // Back part: count, divide and present results.
    ber_back #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_q_ready     (q_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_error_bits  (o_error_bits),
        .o_total_bits  (o_total_bits),
        .o_error_ratio (o_error_ratio)
    );

endmodule

`default_nettype wire
